/* rtl/core/gbpe_pkg.sv */
// ----------------------------------------------------------------------------
// gbpe_pkg: shared types and constants of the glyph bitmap pixel emitter
// Field widths, register codes, reset values and the queue entry type.
// ----------------------------------------------------------------------------
package gbpe_pkg;

  localparam int COL_W   = 10;
  localparam int ROW_W   = 16;
  localparam int BYTE_W  = 8;
  localparam int RB_W    = 6;
  localparam int LH_W    = 8;
  localparam int CFG_IW  = 1;
  localparam int CFG_DW  = 10;

  localparam logic [COL_W-1:0] WRAP_LIMIT_RST  = 10'd639;
  localparam logic [LH_W-1:0]  LINE_HEIGHT_RST = 8'd16;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [0:0] {
    CMD_HEADER = 1'b0,
    CMD_DATA   = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_WRAP_LIMIT  = 1'b0,
    REG_LINE_HEIGHT = 1'b1
  } cfg_idx_t;

  // One data byte, reduced to its pixels that fall inside the glyph
  typedef struct packed {
    logic [BYTE_W-1:0] mask;
    logic [COL_W-1:0]  x_base;
    logic [ROW_W-1:0]  y;
  } work_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Offset from the MSB of the leftmost set bit
  function automatic logic [2:0] first_set(input logic [BYTE_W-1:0] m);
    logic [2:0] pos;
    logic       found;
    pos   = 3'd0;
    found = 1'b0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (!found && m[BYTE_W-1-i]) begin
        pos   = 3'(i);
        found = 1'b1;
      end
    end
    return pos;
  endfunction

endpackage

/* rtl/core/gbpe_in_if.sv */
// ----------------------------------------------------------------------------
// gbpe_in_if: input item channel
// Carries one glyph header or one bitmap byte per beat.
// ----------------------------------------------------------------------------
interface gbpe_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [gbpe_pkg::BYTE_W-1:0] glyph_width;
  logic [gbpe_pkg::BYTE_W-1:0] glyph_height;
  logic [gbpe_pkg::BYTE_W-1:0] advance;
  logic [gbpe_pkg::BYTE_W-1:0] bitmap_byte;

  modport source (output valid, command, glyph_width, glyph_height, advance,
                  bitmap_byte, input ready);
  modport sink   (input valid, command, glyph_width, glyph_height, advance,
                  bitmap_byte, output ready);
endinterface

/* rtl/core/gbpe_out_if.sv */
// ----------------------------------------------------------------------------
// gbpe_out_if: pixel result channel
// Carries one set pixel's screen coordinates per beat.
// ----------------------------------------------------------------------------
interface gbpe_out_if;
  logic                       valid;
  logic                       ready;
  logic [gbpe_pkg::COL_W-1:0] pixel_x;
  logic [gbpe_pkg::ROW_W-1:0] pixel_y;
  logic                       last_of_byte;

  modport source (output valid, pixel_x, pixel_y, last_of_byte, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_of_byte, output ready);
endinterface

/* rtl/core/gbpe_cfg_if.sv */
// ----------------------------------------------------------------------------
// gbpe_cfg_if: configuration write channel
// Carries a register index and write data per beat.
// ----------------------------------------------------------------------------
interface gbpe_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [gbpe_pkg::CFG_IW-1:0] index;
  logic [gbpe_pkg::CFG_DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/gbpe_front.sv */
// ----------------------------------------------------------------------------
// gbpe_front: item classifier and glyph cursor
// Takes headers and data bytes, keeps cursor and glyph state, and queues
// the in-glyph pixel mask of each data byte.
// ----------------------------------------------------------------------------
module gbpe_front (
  input  logic                 clk,
  input  logic                 rst_n,
  gbpe_in_if.sink              in_ch,
  gbpe_cfg_if.sink             cfg_ch,
  input  gbpe_pkg::q_stat_t    q_stat,
  output logic                 push,
  output gbpe_pkg::work_t      push_work
);
  import gbpe_pkg::*;

  logic [COL_W-1:0]  wrap_limit_r, wrap_limit_nxt;
  logic [LH_W-1:0]   line_height_r, line_height_nxt;
  logic [COL_W-1:0]  cursor_col_r, cursor_col_nxt;
  logic [ROW_W-1:0]  cursor_row_r, cursor_row_nxt;
  logic [COL_W-1:0]  origin_col_r, origin_col_nxt;
  logic [ROW_W-1:0]  origin_row_r, origin_row_nxt;
  logic [BYTE_W-1:0] cur_width_r, cur_width_nxt;
  logic [BYTE_W-1:0] cur_height_r, cur_height_nxt;
  logic [RB_W-1:0]   row_bytes_r, row_bytes_nxt;
  logic [BYTE_W-1:0] row_index_r, row_index_nxt;
  logic [RB_W-1:0]   byte_in_row_r, byte_in_row_nxt;

  logic              accept;
  logic              active;
  logic [RB_W-1:0]   hdr_bytes;
  logic [COL_W:0]    wrap_sum;
  logic [COL_W-1:0]  hdr_col;
  logic [ROW_W-1:0]  hdr_row;
  logic [BYTE_W-1:0] col_base;
  logic [BYTE_W-1:0] in_mask;
  logic [BYTE_W:0]   col;
  logic [RB_W-1:0]   bir_inc;

  assign in_ch.ready  = !q_stat.full;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;

  // Classify the beat and work out the next glyph state
  always_comb begin
    wrap_limit_nxt  = wrap_limit_r;
    line_height_nxt = line_height_r;
    cursor_col_nxt  = cursor_col_r;
    cursor_row_nxt  = cursor_row_r;
    origin_col_nxt  = origin_col_r;
    origin_row_nxt  = origin_row_r;
    cur_width_nxt   = cur_width_r;
    cur_height_nxt  = cur_height_r;
    row_bytes_nxt   = row_bytes_r;
    row_index_nxt   = row_index_r;
    byte_in_row_nxt = byte_in_row_r;
    push            = 1'b0;

    hdr_bytes = {1'b0, in_ch.glyph_width[7:3]} + RB_W'(|in_ch.glyph_width[2:0]);
    hdr_bytes = hdr_bytes + RB_W'(hdr_bytes[0]);
    wrap_sum  = {1'b0, cursor_col_r} + (COL_W+1)'(in_ch.advance)
              + (COL_W+1)'(in_ch.glyph_width);
    if (wrap_sum > {1'b0, wrap_limit_r}) begin
      hdr_col = '0;
      hdr_row = cursor_row_r + ROW_W'(line_height_r);
    end else begin
      hdr_col = cursor_col_r;
      hdr_row = cursor_row_r;
    end

    active   = (row_bytes_r != '0) && (row_index_r < cur_height_r);
    col_base = {byte_in_row_r[4:0], 3'b000};
    for (int b = 0; b < BYTE_W; b++) begin
      col = {1'b0, col_base} + (BYTE_W+1)'(b);
      in_mask[BYTE_W-1-b] = in_ch.bitmap_byte[BYTE_W-1-b] &&
                            (col < {1'b0, cur_width_r});
    end
    bir_inc = byte_in_row_r + RB_W'(1);

    push_work.mask   = in_mask;
    push_work.x_base = origin_col_r + COL_W'(col_base);
    push_work.y      = origin_row_r + ROW_W'(row_index_r);

    if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_WRAP_LIMIT:  wrap_limit_nxt  = cfg_ch.data[COL_W-1:0];
        REG_LINE_HEIGHT: line_height_nxt = cfg_ch.data[LH_W-1:0];
        default:         ;
      endcase
    end

    if (accept) begin
      if (in_ch.command == CMD_HEADER) begin
        row_bytes_nxt   = hdr_bytes;
        cur_width_nxt   = in_ch.glyph_width;
        cur_height_nxt  = in_ch.glyph_height;
        origin_col_nxt  = hdr_col;
        origin_row_nxt  = hdr_row;
        cursor_row_nxt  = hdr_row;
        cursor_col_nxt  = hdr_col + COL_W'(in_ch.glyph_width) + COL_W'(in_ch.advance);
        row_index_nxt   = '0;
        byte_in_row_nxt = '0;
      end else if (active) begin
        push = (in_mask != '0);
        if (bir_inc >= row_bytes_r) begin
          byte_in_row_nxt = '0;
          row_index_nxt   = row_index_r + BYTE_W'(1);
        end else begin
          byte_in_row_nxt = bir_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_limit_r  <= WRAP_LIMIT_RST;
      line_height_r <= LINE_HEIGHT_RST;
      cursor_col_r  <= '0;
      cursor_row_r  <= '0;
      origin_col_r  <= '0;
      origin_row_r  <= '0;
      cur_width_r   <= '0;
      cur_height_r  <= '0;
      row_bytes_r   <= '0;
      row_index_r   <= '0;
      byte_in_row_r <= '0;
    end else begin
      wrap_limit_r  <= wrap_limit_nxt;
      line_height_r <= line_height_nxt;
      cursor_col_r  <= cursor_col_nxt;
      cursor_row_r  <= cursor_row_nxt;
      origin_col_r  <= origin_col_nxt;
      origin_row_r  <= origin_row_nxt;
      cur_width_r   <= cur_width_nxt;
      cur_height_r  <= cur_height_nxt;
      row_bytes_r   <= row_bytes_nxt;
      row_index_r   <= row_index_nxt;
      byte_in_row_r <= byte_in_row_nxt;
    end
  end

  // Walk through a row only inside a glyph of non-zero size
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (row_bytes_r != '0) |-> (byte_in_row_r < row_bytes_r))
    else $error("byte position ran past the row");

endmodule

/* rtl/core/gbpe_fifo.sv */
// ----------------------------------------------------------------------------
// gbpe_fifo: work queue between classifier and pixel serialiser
// Small register queue of pixel masks with full and empty flags.
// ----------------------------------------------------------------------------
module gbpe_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  gbpe_pkg::work_t    push_work,
  input  logic               pop,
  output gbpe_pkg::work_t    head,
  output gbpe_pkg::q_stat_t  stat
);
  import gbpe_pkg::*;

  work_t           mem_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]    count_r, count_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == (QAW+1)'(QDEPTH));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_work;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

endmodule

/* rtl/core/gbpe_back.sv */
// ----------------------------------------------------------------------------
// gbpe_back: pixel serialiser
// Emits the set pixels of one queued mask, leftmost first, one per cycle
// while the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module gbpe_back (
  input  logic               clk,
  input  logic               rst_n,
  input  gbpe_pkg::work_t    head,
  input  gbpe_pkg::q_stat_t  q_stat,
  output logic               pop,
  gbpe_out_if.source         out_ch
);
  import gbpe_pkg::*;

  logic [BYTE_W-1:0] mask_r, mask_nxt;
  logic [COL_W-1:0]  x_base_r, x_base_nxt;
  logic [ROW_W-1:0]  y_r, y_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]  out_x_r, out_x_nxt;
  logic [ROW_W-1:0]  out_y_r, out_y_nxt;
  logic              out_last_r, out_last_nxt;

  logic              advance;
  logic              emit;
  logic [2:0]        sel;
  logic [BYTE_W-1:0] rest;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_x      = out_x_r;
  assign out_ch.pixel_y      = out_y_r;
  assign out_ch.last_of_byte = out_last_r;

  always_comb begin
    advance = !out_valid_r || out_ch.ready;
    emit    = advance && (mask_r != '0);
    sel     = first_set(mask_r);
    rest    = mask_r & ~(BYTE_W'(8'h80) >> sel);

    mask_nxt      = mask_r;
    x_base_nxt    = x_base_r;
    y_nxt         = y_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_last_nxt  = out_last_r;

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_x_nxt     = x_base_r + COL_W'(sel);
      out_y_nxt     = y_r;
      out_last_nxt  = (rest == '0);
      mask_nxt      = rest;
    end

    // Refill as the current mask drains, so bytes follow without a gap
    pop = !q_stat.empty && ((mask_r == '0) || (emit && rest == '0));
    if (pop) begin
      mask_nxt   = head.mask;
      x_base_nxt = head.x_base;
      y_nxt      = head.y;
    end
  end

  always_ff @(posedge clk) begin
    x_base_r <= x_base_nxt;
    y_r      <= y_nxt;
    out_x_r  <= out_x_nxt;
    out_y_r  <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (head.mask != '0))
    else $error("queued entry carries no pixels");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && rest == '0 && !pop) |=> (mask_r == '0))
    else $error("mask not drained after last pixel");

endmodule

/* rtl/core/glyph_bitmap_pixel_emitter_core.sv */
// ----------------------------------------------------------------------------
// glyph_bitmap_pixel_emitter_core: 1-bpp font glyph to pixel coordinate stream
// Front classifies headers and bitmap bytes and keeps the cursor; back
// serialises the set pixels of each byte; a short queue sits between them.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                           Beat
//  in_ch    in   command, glyph_width, glyph_height, advance,      header or
//                bitmap_byte                                       data byte
//  out_ch   out  pixel_x, pixel_y, last_of_byte                    one pixel
//  cfg_ch   in   index (0 wrap_limit, 1 line_height), data         reg write
//
//  The front takes one input beat per cycle while the queue has room; a
//  header or an empty byte finishes there and then.
//  The back emits one pixel per cycle while out_ch is not stalled, one per
//  set in-glyph pixel of a byte (up to eight); bytes run back to back.
//  Reset (synchronous, rst_n low) restores wrap_limit 639, line_height 16 and
//  clears cursor, glyph state, queue, serialiser and output valid.
//  An output stall holds the output register and the serialiser; the queue
//  (four entries) keeps taking bytes until it fills, then in_ch.ready drops.
//  Configuration writes are taken in any cycle.
// ----------------------------------------------------------------------------
module glyph_bitmap_pixel_emitter_core (
  input  logic       clk,
  input  logic       rst_n,
  gbpe_in_if.sink    in_ch,
  gbpe_cfg_if.sink   cfg_ch,
  gbpe_out_if.source out_ch
);
  import gbpe_pkg::*;

  logic    push;
  logic    pop;
  work_t   push_work;
  work_t   head;
  q_stat_t q_stat;

  // Classify beats, move the cursor, queue in-glyph pixel masks
  gbpe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_work (push_work)
  );

  // Decouple the two sides
  gbpe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_work (push_work),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // Drain one pixel per cycle, while the output is not stalled, into the output register
  gbpe_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
